[sv/emr_pkg.sv]
package emr_pkg;
  localparam int SLOT_COUNT   = 16;
  localparam int QUEUE_DEPTH  = 32;
  localparam int PAYLOAD_BITS = 64;
  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int STORE_DEPTH = SLOT_COUNT * QUEUE_DEPTH;
  localparam int STORE_W = $clog2(STORE_DEPTH);
  localparam int PKT_W   = 64 + PAYLOAD_BITS;

  localparam logic [2:0] FN_REGISTER   = 3'd0;
  localparam logic [2:0] FN_UNREGISTER = 3'd1;
  localparam logic [2:0] FN_PUBLISH    = 3'd2;
  localparam logic [2:0] FN_RECEIVE    = 3'd3;
  localparam logic [2:0] FN_CHAN_RECV  = 3'd4;

  typedef struct packed {
    logic [31:0]             target;
    logic [31:0]             channel;
    logic [PAYLOAD_BITS-1:0] payload;
  } pkt_t;

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    wrap_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction
endpackage

[sv/event_mailbox_router_unit.sv]
// channel  valid     stall     fields
// in_      in_valid  in_stall  func, process_id, target_id, channel_id, payload
// out_     out_valid out_stall ok, got_target, got_channel, got_payload
//
// register: find pass, then free pass; unregister: one pass over all slots
// publish: ring push on accept plus one slot per cycle
// receive by pid: slot scan, then a store read (S_RRD) if the queue holds a packet
// receive by channel: scan entries, rotate the ones ahead of the match to the tail, fetch the match
// sync reset clears slot table and ring pointers; new beat only after result leaves output
module event_mailbox_router_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_process_id,
  input  logic [31:0] in_target_id,
  input  logic [31:0] in_channel_id,
  input  logic [63:0] in_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [31:0] out_got_target,
  output logic [31:0] out_got_channel,
  output logic [63:0] out_got_payload
);
  localparam int SW = emr_pkg::SLOT_W;
  localparam int PW = emr_pkg::PTR_W;
  localparam int NS = emr_pkg::SLOT_COUNT;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIND  = 4'd1;  // register: look for existing pid
  localparam logic [3:0] S_FREE  = 4'd2;  // register: first free slot
  localparam logic [3:0] S_UNREG = 4'd3;
  localparam logic [3:0] S_PUB   = 4'd4;
  localparam logic [3:0] S_RECV  = 4'd5;
  localparam logic [3:0] S_RRD   = 4'd6;  // slot store read wait
  localparam logic [3:0] S_CRD   = 4'd7;  // ring read wait in scan
  localparam logic [3:0] S_CCMP  = 4'd8;  // compare ring entry
  localparam logic [3:0] S_ROTRD = 4'd9;  // rotate: read head
  localparam logic [3:0] S_ROTWR = 4'd10; // rotate: write tail
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_HRD   = 4'd13; // read new head after rotation

  logic [3:0] state_r, state_nxt;

  logic          slot_active_r [NS];
  logic [31:0]   slot_pid_r    [NS];
  logic [PW-1:0] slot_head_r   [NS];
  logic [PW-1:0] slot_tail_r   [NS];
  logic [PW-1:0] ring_head_r, ring_tail_r;

  logic [31:0] pid_r, chn_r;
  emr_pkg::pkt_t pkt_r;
  logic [SW:0]   idx_r;
  logic [PW:0]   k_r, n_r;
  logic          ok_r;
  emr_pkg::pkt_t got_r;
  logic [SW-1:0] hit_r;

  // shared memories
  logic                      st_we;
  logic [emr_pkg::STORE_W-1:0] st_waddr, st_raddr;
  emr_pkg::pkt_t             st_rdata;
  logic                      rg_we;
  logic [PW-1:0]             rg_waddr, rg_raddr;
  emr_pkg::pkt_t             rg_wdata, rg_rdata;

  emr_ram #(.WIDTH(emr_pkg::PKT_W), .DEPTH(emr_pkg::STORE_DEPTH)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(pkt_r),
    .raddr(st_raddr), .rdata(st_rdata)
  );
  emr_ram #(.WIDTH(emr_pkg::PKT_W), .DEPTH(emr_pkg::QUEUE_DEPTH)) u_ring (
    .clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
    .raddr(rg_raddr), .rdata(rg_rdata)
  );

  // current slot under the shared compare
  logic [SW-1:0] cs;
  logic          c_act, c_match, last;
  assign cs      = idx_r[SW-1:0];
  assign c_act   = slot_active_r[cs];
  assign c_match = c_act && (slot_pid_r[cs] == pid_r);
  assign last    = (idx_r == (SW+1)'(NS - 1));

  logic pub_sel, pub_full;
  assign pub_sel  = c_act && (pkt_r.target == 32'd0 || pkt_r.target == slot_pid_r[cs]);
  assign pub_full = emr_pkg::wrap_next(slot_tail_r[cs]) == slot_head_r[cs];

  logic [PW-1:0] scan_pos;
  assign scan_pos = ring_head_r + k_r[PW-1:0];

  // memory port drive
  always_comb begin
    st_we    = (state_r == S_PUB) && pub_sel && !pub_full;
    st_waddr = {cs, slot_tail_r[cs]};
    st_raddr = {cs, slot_head_r[cs]};
    rg_we    = 1'b0;
    rg_waddr = ring_tail_r;
    rg_wdata = pkt_r;
    rg_raddr = scan_pos;
    if (state_r == S_IDLE) begin
      rg_we = in_valid && in_func == emr_pkg::FN_PUBLISH
              && emr_pkg::wrap_next(ring_tail_r) != ring_head_r;
      rg_wdata = '{in_target_id, in_channel_id, in_payload[emr_pkg::PAYLOAD_BITS-1:0]};
    end else if (state_r == S_ROTRD || state_r == S_ROTWR) begin
      rg_raddr = ring_head_r;
      rg_we    = (state_r == S_ROTWR);
      rg_wdata = rg_rdata;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_ok          = ok_r;
  assign out_got_target  = got_r.target;
  assign out_got_channel = got_r.channel;
  assign out_got_payload = 64'(got_r.payload);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        case (in_func)
          emr_pkg::FN_REGISTER:   state_nxt = S_FIND;
          emr_pkg::FN_UNREGISTER: state_nxt = S_UNREG;
          emr_pkg::FN_PUBLISH:    state_nxt = S_PUB;
          emr_pkg::FN_RECEIVE:    state_nxt = S_RECV;
          emr_pkg::FN_CHAN_RECV:  state_nxt = S_CRD;
          default:                state_nxt = S_OUT;
        endcase
      end
      S_FIND:  if (c_match) state_nxt = S_OUT; else if (last) state_nxt = S_FREE;
      S_FREE:  if (!c_act || last) state_nxt = S_OUT;
      S_UNREG: if (last) state_nxt = S_OUT;
      S_PUB:   if (last) state_nxt = S_OUT;
      S_RECV: begin
        if (c_match) state_nxt = (slot_head_r[cs] != slot_tail_r[cs]) ? S_RRD : S_OUT;
        else if (last) state_nxt = S_OUT;
      end
      S_RRD:   state_nxt = S_OUT;
      S_CRD:   state_nxt = (k_r >= n_r) ? S_OUT : S_CCMP;
      S_CCMP:  state_nxt = (rg_rdata.channel == chn_r)
                           ? ((k_r == '0) ? S_DONE : S_ROTRD) : S_CRD;
      S_ROTRD: state_nxt = S_ROTWR;
      S_ROTWR: state_nxt = (k_r == (PW+1)'(1)) ? S_HRD : S_ROTRD;
      S_HRD:   state_nxt = S_DONE;
      S_DONE:  state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ring_head_r <= '0;
      ring_tail_r <= '0;
      for (int i = 0; i < NS; i++) begin
        slot_active_r[i] <= 1'b0;
        slot_pid_r[i]    <= '0;
        slot_head_r[i]   <= '0;
        slot_tail_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (in_valid) begin
          pid_r  <= in_process_id;
          chn_r  <= in_channel_id;
          pkt_r  <= '{in_target_id, in_channel_id, in_payload[emr_pkg::PAYLOAD_BITS-1:0]};
          idx_r  <= '0;
          k_r    <= '0;
          n_r    <= {1'b0, ring_tail_r - ring_head_r};
          got_r  <= '0;
          ok_r   <= rg_we;
          if (rg_we) ring_tail_r <= emr_pkg::wrap_next(ring_tail_r);
        end
        S_FIND: begin
          if (c_match) ok_r <= 1'b1;
          idx_r <= last ? '0 : idx_r + 1'b1;
        end
        S_FREE: begin
          if (!c_act) begin
            slot_active_r[cs] <= 1'b1;
            slot_pid_r[cs]    <= pid_r;
            slot_head_r[cs]   <= '0;
            slot_tail_r[cs]   <= '0;
            ok_r <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        S_UNREG: begin
          if (c_match) begin
            slot_active_r[cs] <= 1'b0;
            slot_pid_r[cs]    <= '0;
            slot_head_r[cs]   <= '0;
            slot_tail_r[cs]   <= '0;
            ok_r <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        S_PUB: begin
          if (st_we) begin
            slot_tail_r[cs] <= emr_pkg::wrap_next(slot_tail_r[cs]);
            ok_r <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        S_RECV: begin
          if (c_match) hit_r <= cs;
          else idx_r <= idx_r + 1'b1;
        end
        S_RRD: begin
          got_r <= st_rdata;
          ok_r  <= 1'b1;
          slot_head_r[hit_r] <= emr_pkg::wrap_next(slot_head_r[hit_r]);
        end
        S_CCMP: if (rg_rdata.channel != chn_r) k_r <= k_r + 1'b1;
        S_ROTWR: begin
          ring_head_r <= emr_pkg::wrap_next(ring_head_r);
          ring_tail_r <= emr_pkg::wrap_next(ring_tail_r);
          k_r <= k_r - 1'b1;
        end
        S_DONE: begin
          got_r <= rg_rdata;
          ok_r  <= 1'b1;
          ring_head_r <= emr_pkg::wrap_next(ring_head_r);
        end
        default: ;
      endcase
    end
  end

  // S_DONE takes the beat that the ring read at ring_head_r in the preceding state
`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("beat taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) && $stable(out_got_payload))
    else $error("result changed under stall");
  a_ring_not_overfull: assert property (@(posedge clk) disable iff (!rst_n)
    emr_pkg::wrap_next(ring_tail_r) == ring_head_r |=> ring_tail_r != ring_head_r
    || $past(state_r) == S_DONE) else $error("ring overflow");
`endif
endmodule

[sv/emr_ram.sv]
module emr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[tb/event_mailbox_router_unit_tb.sv]
module event_mailbox_router_unit_tb;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] pid;
    logic [31:0] tgt;
    logic [31:0] chn;
    logic [63:0] pay;
  } request_t;

  typedef struct {
    logic        ok;
    logic [31:0] gt;
    logic [31:0] gc;
    logic [63:0] gp;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = '0;
  logic [31:0] in_process_id = '0;
  logic [31:0] in_target_id = '0;
  logic [31:0] in_channel_id = '0;
  logic [63:0] in_payload = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic [31:0] out_got_target;
  logic [31:0] out_got_channel;
  logic [63:0] out_got_payload;

  event_mailbox_router_unit dut (.*);

  // router mirror state
  logic                      mb_active [emr_pkg::SLOT_COUNT];
  logic [31:0]               mb_pid    [emr_pkg::SLOT_COUNT];
  logic [emr_pkg::PTR_W-1:0] mb_head   [emr_pkg::SLOT_COUNT];
  logic [emr_pkg::PTR_W-1:0] mb_tail   [emr_pkg::SLOT_COUNT];
  emr_pkg::pkt_t             mb_store  [emr_pkg::SLOT_COUNT][emr_pkg::QUEUE_DEPTH];
  logic [emr_pkg::PTR_W-1:0] chan_head;
  logic [emr_pkg::PTR_W-1:0] chan_tail;
  emr_pkg::pkt_t             chan_ring [emr_pkg::QUEUE_DEPTH];

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  int       mismatches = 0;
  int       beats_sent = 0;
  int       replies_seen = 0;
  int       send_gap = 0;
  int       hold_left = 0;
  bit       long_hold_done = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #20000000;
    $display("event_mailbox_router_unit verification failed");
    $finish;
  end

  function automatic logic [emr_pkg::PTR_W-1:0] ptr_inc(input logic [emr_pkg::PTR_W-1:0] p);
    ptr_inc = (int'(p) == emr_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // work out the reply of one beat and advance the mirror state
  function automatic reply_t route_request(input request_t rq);
    reply_t        rp;
    emr_pkg::pkt_t pk;
    bit            done;
    int            n, k;
    rp = '{1'b0, 32'd0, 32'd0, 64'd0};
    pk.target  = rq.tgt;
    pk.channel = rq.chn;
    pk.payload = rq.pay[emr_pkg::PAYLOAD_BITS-1:0];
    case (rq.func)
      emr_pkg::FN_REGISTER: begin
        done = 0;
        for (int s = 0; s < emr_pkg::SLOT_COUNT; s++)
          if (mb_active[s] && mb_pid[s] == rq.pid) done = 1;
        for (int s = 0; s < emr_pkg::SLOT_COUNT && !done; s++)
          if (!mb_active[s]) begin
            mb_active[s] = 1'b1;
            mb_pid[s] = rq.pid;
            mb_head[s] = '0;
            mb_tail[s] = '0;
            done = 1;
          end
        rp.ok = done;
      end
      emr_pkg::FN_UNREGISTER: begin
        for (int s = 0; s < emr_pkg::SLOT_COUNT; s++)
          if (mb_active[s] && mb_pid[s] == rq.pid) begin
            mb_active[s] = 1'b0;
            mb_pid[s] = '0;
            mb_head[s] = '0;
            mb_tail[s] = '0;
            rp.ok = 1'b1;
          end
      end
      emr_pkg::FN_PUBLISH: begin
        if (ptr_inc(chan_tail) != chan_head) begin
          chan_ring[chan_tail] = pk;
          chan_tail = ptr_inc(chan_tail);
          rp.ok = 1'b1;
        end
        for (int s = 0; s < emr_pkg::SLOT_COUNT; s++)
          if (mb_active[s] && (rq.tgt == 0 || rq.tgt == mb_pid[s]) &&
              ptr_inc(mb_tail[s]) != mb_head[s]) begin
            mb_store[s][mb_tail[s]] = pk;
            mb_tail[s] = ptr_inc(mb_tail[s]);
            rp.ok = 1'b1;
          end
      end
      emr_pkg::FN_RECEIVE: begin
        done = 0;
        for (int s = 0; s < emr_pkg::SLOT_COUNT && !done; s++)
          if (mb_active[s] && mb_pid[s] == rq.pid) begin
            done = 1;
            if (mb_head[s] != mb_tail[s]) begin
              rp.gt = mb_store[s][mb_head[s]].target;
              rp.gc = mb_store[s][mb_head[s]].channel;
              rp.gp = 64'(mb_store[s][mb_head[s]].payload);
              mb_head[s] = ptr_inc(mb_head[s]);
              rp.ok = 1'b1;
            end
          end
      end
      emr_pkg::FN_CHAN_RECV: begin
        n = (int'(chan_tail) + emr_pkg::QUEUE_DEPTH - int'(chan_head)) % emr_pkg::QUEUE_DEPTH;
        for (k = 0; k < n; k++)
          if (chan_ring[(int'(chan_head) + k) % emr_pkg::QUEUE_DEPTH].channel == rq.chn)
            break;
        if (k < n) begin
          // packets ahead of the match go to the back in order
          for (int i = 0; i < k; i++) begin
            chan_ring[chan_tail] = chan_ring[chan_head];
            chan_head = ptr_inc(chan_head);
            chan_tail = ptr_inc(chan_tail);
          end
          rp.gt = chan_ring[chan_head].target;
          rp.gc = chan_ring[chan_head].channel;
          rp.gp = 64'(chan_ring[chan_head].payload);
          chan_head = ptr_inc(chan_head);
          rp.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return rp;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s at reply %0d: got %h want %h", what, replies_seen, got, want);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_pid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return 32'($urandom_range(1, 20));
    if (r < 92) return 32'hFFFF_FFFF;
    if (r < 95) return 32'd0;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 32'($urandom_range(0, 5));
    if (r < 90) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic request_t make_request(input logic [2:0] f, input logic [31:0] p,
                                            input logic [31:0] t, input logic [31:0] c,
                                            input logic [63:0] d);
    request_t rq;
    rq.func = f;
    rq.pid = p;
    rq.tgt = t;
    rq.chn = c;
    rq.pay = d;
    return rq;
  endfunction

  // stimulus: directed corners, then mixed random traffic
  initial begin
    int r;
    logic [2:0]  f;
    logic [31:0] t;
    for (int i = 0; i < emr_pkg::SLOT_COUNT; i++) begin
      mb_active[i] = 1'b0;
      mb_pid[i] = '0;
      mb_head[i] = '0;
      mb_tail[i] = '0;
    end
    chan_head = '0;
    chan_tail = '0;
    pending_requests.push_back(make_request(emr_pkg::FN_RECEIVE, 32'd7, 0, 0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_CHAN_RECV, 0, 0, 32'd0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_REGISTER, 32'hFFFF_FFFF, 0, 0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_REGISTER, 32'd0, 0, 0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_REGISTER, 32'hFFFF_FFFF, 0, 0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_PUBLISH, 0, 32'd0, 32'd0, '1));
    pending_requests.push_back(make_request(emr_pkg::FN_PUBLISH, 0, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF, 64'd0));
    pending_requests.push_back(make_request(emr_pkg::FN_PUBLISH, 0, 32'd55, 32'd3,
                                            64'hA5A5_5A5A_0F0F_F0F0));
    pending_requests.push_back(make_request(emr_pkg::FN_RECEIVE, 32'hFFFF_FFFF, 0, 0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_RECEIVE, 32'd0, 0, 0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_RECEIVE, 32'hFFFF_FFFF, 0, 0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_RECEIVE, 32'hFFFF_FFFF, 0, 0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_CHAN_RECV, 0, 0, 32'hFFFF_FFFF, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_CHAN_RECV, 0, 0, 32'd12345, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_CHAN_RECV, 0, 0, 32'd3, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_CHAN_RECV, 0, 0, 32'd0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_CHAN_RECV, 0, 0, 32'd0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_UNREGISTER, 32'd0, 0, 0, 0));
    pending_requests.push_back(make_request(emr_pkg::FN_UNREGISTER, 32'd99, 0, 0, 0));
    pending_requests.push_back(make_request(3'd5, '1, '1, '1, '1));
    pending_requests.push_back(make_request(3'd6, 32'd1, 0, 0, 0));
    pending_requests.push_back(make_request(3'd7, 32'hFFFF_FFFF, 0, 0, 0));
    for (int i = 0; i < 1700; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) f = emr_pkg::FN_REGISTER;
      else if (r < 18) f = emr_pkg::FN_UNREGISTER;
      else if (r < 52) f = emr_pkg::FN_PUBLISH;
      else if (r < 74) f = emr_pkg::FN_RECEIVE;
      else if (r < 97) f = emr_pkg::FN_CHAN_RECV;
      else f = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 99);
      t = (r < 25) ? 32'd0 : pick_pid();
      pending_requests.push_back(make_request(f, pick_pid(), t, pick_channel(),
                                              {$urandom, $urandom}));
    end
  end

  // driver: offer queued beats with random gaps, bursts without gaps
  always @(posedge clk) begin
    request_t rq;
    bit       taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        rq = make_request(in_func, in_process_id, in_target_id, in_channel_id, in_payload);
        expected_replies.push_back(route_request(rq));
        beats_sent++;
      end
      if (!in_valid || taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          rq = pending_requests.pop_front();
          in_func <= rq.func;
          in_process_id <= rq.pid;
          in_target_id <= rq.tgt;
          in_channel_id <= rq.chn;
          in_payload <= rq.pay;
          in_valid <= 1'b1;
          send_gap <= ((beats_sent / 150) % 3 == 1) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall, one long hold-off, compare each reply beat
  always @(posedge clk) begin
    reply_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report("unexpected beat", 64'(out_ok), 64'd0);
        end else begin
          want = expected_replies.pop_front();
          if (out_ok !== want.ok) report("ok", 64'(out_ok), 64'(want.ok));
          if (out_got_target !== want.gt) report("got_target", 64'(out_got_target), 64'(want.gt));
          if (out_got_channel !== want.gc)
            report("got_channel", 64'(out_got_channel), 64'(want.gc));
          if (out_got_payload !== want.gp) report("got_payload", out_got_payload, want.gp);
        end
        replies_seen++;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!long_hold_done && replies_seen >= 400) begin
        long_hold_done <= 1'b1;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else if ((replies_seen / 200) % 3 == 2) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 9) < 3);
        if ($urandom_range(0, 49) == 0) hold_left <= pick_gap();
      end
    end
  end

  // end of run
  initial begin
    wait (rst_n);
    wait (pending_requests.size() == 0 && !in_valid && expected_replies.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("event_mailbox_router_unit verification clean");
    end else begin
      $display("event_mailbox_router_unit verification failed");
    end
    $finish;
  end
endmodule
